// File: src/sgt_pkg.sv
`default_nettype none
package sgt_pkg;

   localparam int DEF_SCOPE_SLOTS = 16;
   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_MAX_LINKS   = 8;
   localparam int DEF_STACK_DEPTH = 32;
   localparam int DEF_TOKEN_BITS  = 16;

   localparam logic [3:0] CMD_LOAD_SCOPE  = 4'd0;
   localparam logic [3:0] CMD_LOAD_ENTRY  = 4'd1;
   localparam logic [3:0] CMD_LOAD_LINK   = 4'd2;
   localparam logic [3:0] CMD_SET_CURRENT = 4'd3;
   localparam logic [3:0] CMD_ENTER_NEXT  = 4'd4;
   localparam logic [3:0] CMD_ENTER_NAMED = 4'd5;
   localparam logic [3:0] CMD_ENTRY_NEXT  = 4'd6;
   localparam logic [3:0] CMD_ENTRY_NAMED = 4'd7;
   localparam logic [3:0] CMD_LEAVE       = 4'd8;
   localparam logic [3:0] CMD_CLEAR       = 4'd9;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_PARENT    = 3'd2;
   localparam logic [2:0] STAT_KIND      = 3'd3;
   localparam logic [2:0] STAT_MISMATCH  = 3'd4;
   localparam logic [2:0] STAT_NO_SCOPE  = 3'd5;
   localparam logic [2:0] STAT_OVERFLOW  = 3'd6;

   typedef struct packed {
      logic [3:0]  command;
      logic [3:0]  scope_slot;
      logic [15:0] scope_ident;
      logic [3:0]  entry_slot;
      logic [2:0]  link_slot;
      logic [15:0] entry_token;
      logic [15:0] subscope_token;
      logic        expr_present;
      logic [15:0] expr_number;
      logic [4:0]  item_count;
      logic [3:0]  target_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] matched_expr;
      logic [15:0] matched_token;
      logic [5:0]  stack_level;
   } rsp_type;

   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_EXEC       = 10'b0000000010,
      S_SCAN_SCOPE = 10'b0000000100,
      S_GET_CNT    = 10'b0000001000,
      S_NEXT_ENT   = 10'b0000010000,
      S_NAME_SCAN  = 10'b0000100000,
      S_LINK_SCAN  = 10'b0001000000,
      S_PUSH       = 10'b0010000000,
      S_LEAVE      = 10'b0100000000,
      S_DONE       = 10'b1000000000
   } state_type;

endpackage
`default_nettype wire

// File: src/sgt_ram.sv
`default_nettype none
module sgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: src/scope_grammar_tracker_unit.sv
`default_nettype none
// channel   ports                          moves
// req       req_valid req_ready req_data   one command per transfer
// rsp       rsp_valid rsp_ready rsp_data   one result per command
//
// one command at a time; loads, clear and unused codes go from S_EXEC straight to S_DONE
// set current reads the scope slots in order from slot 0 until a valid one has the identifier
// named and enter commands read the entries scanned and then the links scanned one at a time,
// through the one read port of the entry and link memories
// leave reads the stack memory, but not from one level; reset empties stack and scope valid bits
// a result waiting in the output register does not block the next request
module scope_grammar_tracker_unit #(
   parameter int SCOPE_SLOTS = sgt_pkg::DEF_SCOPE_SLOTS,
   parameter int MAX_ENTRIES = sgt_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_LINKS   = sgt_pkg::DEF_MAX_LINKS,
   parameter int STACK_DEPTH = sgt_pkg::DEF_STACK_DEPTH,
   parameter int TOKEN_BITS  = sgt_pkg::DEF_TOKEN_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sgt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sgt_pkg::rsp_type      rsp_data
);

   import sgt_pkg::*;

   localparam int SW   = $clog2(SCOPE_SLOTS);
   localparam int SSW  = $clog2(SCOPE_SLOTS + 1);
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int LCW  = $clog2(MAX_LINKS + 1);
   localparam int ECELLS = SCOPE_SLOTS * MAX_ENTRIES;
   localparam int LCELLS = ECELLS * MAX_LINKS;
   localparam int EAW  = $clog2(ECELLS);
   localparam int LAW  = $clog2(LCELLS);
   localparam int DW   = $clog2(STACK_DEPTH);
   localparam int TW   = $clog2(STACK_DEPTH + 1);
   localparam int SCW  = 16 + CW;
   localparam int ENW  = TOKEN_BITS + 1 + 16 + LCW;
   localparam int LKW  = TOKEN_BITS + 4;
   localparam int STW  = SSW + CW;
   localparam logic [SSW-1:0] NULL_SCOPE = SSW'(SCOPE_SLOTS);

   function automatic logic [EAW-1:0] ent_at(input logic [SSW-1:0] s, input logic [CW-1:0] i);
      return EAW'(32'(s) * MAX_ENTRIES + 32'(i));
   endfunction

   function automatic logic [LAW-1:0] lk_at(input logic [EAW-1:0] e, input logic [LCW-1:0] j);
      return LAW'(32'(e) * MAX_LINKS + 32'(j));
   endfunction

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [SCOPE_SLOTS-1:0] valid_ff, valid_in;
   logic [TW-1:0]         top_ff, top_in;
   logic [SSW-1:0]        top_scope_ff, top_scope_in;
   logic [CW-1:0]         top_next_ff, top_next_in;
   logic [SSW-1:0]        sidx_ff, sidx_in;
   logic [CW-1:0]         eidx_ff, eidx_in;
   logic [LCW-1:0]        lidx_ff, lidx_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [EAW-1:0]        ent_addr_ff, ent_addr_in;
   logic [TOKEN_BITS-1:0] ent_name_ff, ent_name_in;
   logic [LCW-1:0]        ent_lc_ff, ent_lc_in;
   logic [SSW-1:0]        push_scope_ff, push_scope_in;
   logic [2:0]            status_ff, status_in;
   logic [15:0]           mexpr_ff, mexpr_in;
   logic [15:0]           mtok_ff, mtok_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  sc_we, en_we, lk_we, st_we;
   logic [SW-1:0]         sc_waddr, sc_raddr;
   logic [EAW-1:0]        en_waddr, en_raddr;
   logic [LAW-1:0]        lk_waddr, lk_raddr;
   logic [DW-1:0]         st_waddr, st_raddr;
   logic [SCW-1:0]        sc_wdata, sc_rdata;
   logic [ENW-1:0]        en_wdata, en_rdata;
   logic [LKW-1:0]        lk_wdata, lk_rdata;
   logic [STW-1:0]        st_wdata, st_rdata;

   logic [15:0]           sc_rid;
   logic [CW-1:0]         sc_rcnt;
   logic [TOKEN_BITS-1:0] en_rname;
   logic                  en_rhas;
   logic [15:0]           en_rexpr;
   logic [LCW-1:0]        en_rlc;
   logic [TOKEN_BITS-1:0] lk_rtok;
   logic [3:0]            lk_rtgt;
   logic [SSW-1:0]        st_rscope;
   logic [CW-1:0]         st_rnext;

   logic [TOKEN_BITS-1:0] etok, stok;
   logic                  s_ok, is_enter, in_scope, tgt_ok;
   logic                  found_go, link_go, miss_go;
   logic [CW-1:0]         eidx_inc;

   assign {sc_rid, sc_rcnt} = sc_rdata;
   assign {en_rname, en_rhas, en_rexpr, en_rlc} = en_rdata;
   assign {lk_rtok, lk_rtgt} = lk_rdata;
   assign {st_rscope, st_rnext} = st_rdata;

   assign etok     = TOKEN_BITS'(req_ff.entry_token);
   assign stok     = TOKEN_BITS'(req_ff.subscope_token);
   assign s_ok     = (32'(top_scope_ff) < SCOPE_SLOTS) && valid_ff[top_scope_ff[SW-1:0]];
   assign tgt_ok   = (32'(lk_rtgt) < SCOPE_SLOTS) && valid_ff[SW'(lk_rtgt)];
   assign is_enter = (req_ff.command == CMD_ENTER_NEXT) || (req_ff.command == CMD_ENTER_NAMED);
   assign in_scope = (32'(req_ff.scope_slot) < SCOPE_SLOTS)
                     && (32'(req_ff.entry_slot) < MAX_ENTRIES);
   assign eidx_inc = CW'(eidx_ff + 1'b1);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      top_in        = top_ff;
      top_scope_in  = top_scope_ff;
      top_next_in   = top_next_ff;
      sidx_in       = sidx_ff;
      eidx_in       = eidx_ff;
      lidx_in       = lidx_ff;
      cnt_in        = cnt_ff;
      ent_addr_in   = ent_addr_ff;
      ent_name_in   = ent_name_ff;
      ent_lc_in     = ent_lc_ff;
      push_scope_in = push_scope_ff;
      status_in     = status_ff;
      mexpr_in      = mexpr_ff;
      mtok_in       = mtok_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      sc_we = 1'b0; sc_waddr = '0; sc_wdata = '0; sc_raddr = '0;
      en_we = 1'b0; en_waddr = '0; en_wdata = '0; en_raddr = '0;
      lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0; lk_raddr = '0;
      st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
      found_go = 1'b0;
      link_go  = 1'b0;
      miss_go  = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = STAT_OK;
               mexpr_in  = '0;
               mtok_in   = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (req_ff.command)
               CMD_LOAD_SCOPE: begin
                  if (32'(req_ff.scope_slot) < SCOPE_SLOTS) begin
                     sc_we    = 1'b1;
                     sc_waddr = SW'(req_ff.scope_slot);
                     sc_wdata = {req_ff.scope_ident,
                                 (32'(req_ff.item_count) > MAX_ENTRIES) ?
                                    CW'(MAX_ENTRIES) : CW'(req_ff.item_count)};
                     valid_in[SW'(req_ff.scope_slot)] = 1'b1;
                  end
               end
               CMD_LOAD_ENTRY: begin
                  if (in_scope) begin
                     en_we    = 1'b1;
                     en_waddr = EAW'(32'(req_ff.scope_slot) * MAX_ENTRIES
                                     + 32'(req_ff.entry_slot));
                     en_wdata = {etok, req_ff.expr_present, req_ff.expr_number,
                                 (32'(req_ff.item_count) > MAX_LINKS) ?
                                    LCW'(MAX_LINKS) : LCW'(req_ff.item_count)};
                  end
               end
               CMD_LOAD_LINK: begin
                  if (in_scope && (32'(req_ff.link_slot) < MAX_LINKS)) begin
                     lk_we    = 1'b1;
                     lk_waddr = LAW'((32'(req_ff.scope_slot) * MAX_ENTRIES
                                      + 32'(req_ff.entry_slot)) * MAX_LINKS
                                     + 32'(req_ff.link_slot));
                     lk_wdata = {stok, req_ff.target_slot};
                  end
               end
               CMD_SET_CURRENT: begin
                  sidx_in  = '0;
                  sc_raddr = '0;
                  state_in = S_SCAN_SCOPE;
               end
               CMD_ENTER_NEXT, CMD_ENTER_NAMED, CMD_ENTRY_NEXT, CMD_ENTRY_NAMED: begin
                  if (top_ff == '0) begin
                     status_in = STAT_NO_SCOPE;
                  end else if (is_enter && (32'(top_ff) >= STACK_DEPTH)) begin
                     status_in = STAT_OVERFLOW;
                  end else if (!s_ok) begin
                     status_in = STAT_PARENT;
                     if (is_enter) begin
                        push_scope_in = NULL_SCOPE;
                        state_in      = S_PUSH;
                     end
                  end else begin
                     sc_raddr = top_scope_ff[SW-1:0];
                     state_in = S_GET_CNT;
                  end
               end
               CMD_LEAVE: begin
                  if (top_ff == '0) begin
                     status_in = STAT_NO_SCOPE;
                  end else begin
                     top_in = TW'(top_ff - 1'b1);
                     if (32'(top_ff) >= 2) begin
                        st_raddr = DW'(top_ff - TW'(2));
                        state_in = S_LEAVE;
                     end
                  end
               end
               CMD_CLEAR: begin
                  top_in   = '0;
                  valid_in = '0;
               end
               default: ;
            endcase
         end
         S_SCAN_SCOPE: begin
            if (valid_ff[sidx_ff[SW-1:0]] && (sc_rid == req_ff.scope_ident)) begin
               top_in       = TW'(1);
               top_scope_in = sidx_ff;
               top_next_in  = '0;
               status_in    = STAT_OK;
               state_in     = S_DONE;
            end else if (32'(sidx_ff) >= SCOPE_SLOTS - 1) begin
               top_in       = TW'(1);
               top_scope_in = NULL_SCOPE;
               top_next_in  = '0;
               status_in    = STAT_NOT_FOUND;
               state_in     = S_DONE;
            end else begin
               sidx_in  = SSW'(sidx_ff + 1'b1);
               sc_raddr = SW'(sidx_ff + 1'b1);
            end
         end
         S_GET_CNT: begin
            cnt_in = sc_rcnt;
            if (top_next_ff < sc_rcnt) begin
               eidx_in  = top_next_ff;
               en_raddr = ent_at(top_scope_ff, top_next_ff);
               state_in = S_NEXT_ENT;
            end else begin
               case (req_ff.command)
                  CMD_ENTER_NEXT: begin
                     status_in     = STAT_MISMATCH;
                     push_scope_in = NULL_SCOPE;
                     state_in      = S_PUSH;
                  end
                  CMD_ENTRY_NEXT: begin
                     status_in = STAT_MISMATCH;
                     state_in  = S_DONE;
                  end
                  default: begin
                     if (sc_rcnt != '0) begin
                        eidx_in  = '0;
                        en_raddr = ent_at(top_scope_ff, '0);
                        state_in = S_NAME_SCAN;
                     end else begin
                        miss_go = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_NEXT_ENT: begin
            ent_addr_in = ent_at(top_scope_ff, eidx_ff);
            ent_name_in = en_rname;
            ent_lc_in   = en_rlc;
            case (req_ff.command)
               CMD_ENTRY_NEXT: begin
                  if (en_rhas) begin
                     mexpr_in    = en_rexpr;
                     mtok_in     = 16'(en_rname);
                     top_next_in = eidx_inc;
                     status_in   = STAT_OK;
                  end else begin
                     status_in = STAT_MISMATCH;
                  end
                  state_in = S_DONE;
               end
               CMD_ENTER_NEXT: begin
                  link_go = 1'b1;
               end
               default: begin
                  if (en_rname == etok) begin
                     found_go = 1'b1;
                  end else if (cnt_ff != '0) begin
                     eidx_in  = '0;
                     en_raddr = ent_at(top_scope_ff, '0);
                     state_in = S_NAME_SCAN;
                  end else begin
                     miss_go = 1'b1;
                  end
               end
            endcase
         end
         S_NAME_SCAN: begin
            ent_addr_in = ent_at(top_scope_ff, eidx_ff);
            ent_name_in = en_rname;
            ent_lc_in   = en_rlc;
            if (en_rname == etok) begin
               found_go = 1'b1;
            end else if (eidx_inc < cnt_ff) begin
               eidx_in  = eidx_inc;
               en_raddr = ent_at(top_scope_ff, eidx_inc);
            end else begin
               miss_go = 1'b1;
            end
         end
         S_LINK_SCAN: begin
            if (lk_rtok == stok) begin
               if (req_ff.command == CMD_ENTER_NEXT) begin
                  mtok_in     = 16'(ent_name_ff);
                  top_next_in = CW'(top_next_ff + 1'b1);
               end
               if (tgt_ok) begin
                  push_scope_in = SSW'(lk_rtgt);
                  status_in     = STAT_OK;
               end else begin
                  push_scope_in = NULL_SCOPE;
                  status_in     = STAT_NOT_FOUND;
               end
               state_in = S_PUSH;
            end else if (32'(lidx_ff) + 1 < 32'(ent_lc_ff)) begin
               lidx_in  = LCW'(lidx_ff + 1'b1);
               lk_raddr = lk_at(ent_addr_ff, LCW'(lidx_ff + 1'b1));
            end else begin
               status_in     = STAT_KIND;
               push_scope_in = NULL_SCOPE;
               state_in      = S_PUSH;
            end
         end
         S_PUSH: begin
            st_we        = 1'b1;
            st_waddr     = DW'(top_ff - 1'b1);
            st_wdata     = {top_scope_ff, top_next_ff};
            top_scope_in = push_scope_ff;
            top_next_in  = '0;
            top_in       = TW'(top_ff + 1'b1);
            state_in     = S_DONE;
         end
         S_LEAVE: begin
            top_scope_in = st_rscope;
            top_next_in  = st_rnext;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status        = status_ff;
               rsp_in.matched_expr  = mexpr_ff;
               rsp_in.matched_token = mtok_ff;
               rsp_in.stack_level   = 6'(top_ff);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (found_go) begin
         mtok_in = 16'(en_rname);
         if (req_ff.command == CMD_ENTER_NAMED) begin
            top_next_in = eidx_inc;
            link_go     = 1'b1;
         end else begin
            if (en_rhas) begin
               mexpr_in    = en_rexpr;
               top_next_in = eidx_inc;
               status_in   = STAT_OK;
            end else begin
               status_in = STAT_KIND;
            end
            state_in = S_DONE;
         end
      end

      if (link_go) begin
         if (en_rlc != '0) begin
            lidx_in  = '0;
            lk_raddr = lk_at(ent_at(top_scope_ff, eidx_ff), '0);
            state_in = S_LINK_SCAN;
         end else begin
            status_in     = STAT_KIND;
            push_scope_in = NULL_SCOPE;
            state_in      = S_PUSH;
         end
      end

      if (miss_go) begin
         status_in = STAT_NOT_FOUND;
         if (req_ff.command == CMD_ENTER_NAMED) begin
            push_scope_in = NULL_SCOPE;
            state_in      = S_PUSH;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      top_scope_ff  <= top_scope_in;
      top_next_ff   <= top_next_in;
      sidx_ff       <= sidx_in;
      eidx_ff       <= eidx_in;
      lidx_ff       <= lidx_in;
      cnt_ff        <= cnt_in;
      ent_addr_ff   <= ent_addr_in;
      ent_name_ff   <= ent_name_in;
      ent_lc_ff     <= ent_lc_in;
      push_scope_ff <= push_scope_in;
      status_ff     <= status_in;
      mexpr_ff      <= mexpr_in;
      mtok_ff       <= mtok_in;
      rsp_ff        <= rsp_in;
   end

   sgt_ram #(.WIDTH(SCW), .DEPTH(SCOPE_SLOTS)) u_scope_ram (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
      .raddr(sc_raddr), .rdata(sc_rdata)
   );

   sgt_ram #(.WIDTH(ENW), .DEPTH(ECELLS)) u_entry_ram (
      .clock(clock), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
      .raddr(en_raddr), .rdata(en_rdata)
   );

   sgt_ram #(.WIDTH(LKW), .DEPTH(LCELLS)) u_link_ram (
      .clock(clock), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
      .raddr(lk_raddr), .rdata(lk_rdata)
   );

   sgt_ram #(.WIDTH(STW), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata)
   );

endmodule
`default_nettype wire

// File: test/scope_grammar_tracker_unit_test.sv
`default_nettype none
module scope_grammar_tracker_unit_test;
   import sgt_pkg::*;

   localparam int SLOTS      = DEF_SCOPE_SLOTS;
   localparam int ENTRIES    = DEF_MAX_ENTRIES;
   localparam int LINKS      = DEF_MAX_LINKS;
   localparam int DEPTH      = DEF_STACK_DEPTH;
   localparam int NULL_SLOT  = SLOTS;
   localparam int ITEM_GOAL  = 1050;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 400;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   scope_grammar_tracker_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   // grammar tables and parse stack as the block should hold them
   logic [15:0] slot_ident [SLOTS];
   bit          scope_live [SLOTS];
   int          scope_count[SLOTS];
   logic [15:0] ent_name   [SLOTS*ENTRIES];
   bit          ent_has    [SLOTS*ENTRIES];
   logic [15:0] ent_expr   [SLOTS*ENTRIES];
   int          ent_links  [SLOTS*ENTRIES];
   bit          ent_written[SLOTS*ENTRIES];
   logic [15:0] lnk_token  [SLOTS*ENTRIES*LINKS];
   int          lnk_target [SLOTS*ENTRIES*LINKS];
   bit          lnk_written[SLOTS*ENTRIES*LINKS];
   int          stk_scope  [DEPTH];
   int          stk_next   [DEPTH];
   int          stk_depth;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[$];
   int           mismatches;
   int           items_sent;
   int           results_seen;
   int           status_seen[8];
   int           idle_cycles;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic req_type mk(logic [3:0] cmd, int ss, logic [15:0] id, int es, int ls,
                                  logic [15:0] etok, logic [15:0] stok, bit ep,
                                  logic [15:0] en, int cnt, int tgt);
      req_type r;
      r.command        = cmd;
      r.scope_slot     = ss[3:0];
      r.scope_ident    = id;
      r.entry_slot     = es[3:0];
      r.link_slot      = ls[2:0];
      r.entry_token    = etok;
      r.subscope_token = stok;
      r.expr_present   = ep;
      r.expr_number    = en;
      r.item_count     = cnt[4:0];
      r.target_slot    = tgt[3:0];
      return r;
   endfunction

   function automatic rsp_type res(logic [2:0] st, logic [15:0] mx, logic [15:0] mt, int lvl);
      rsp_type y;
      y.status        = st;
      y.matched_expr  = mx;
      y.matched_token = mt;
      y.stack_level   = lvl[5:0];
      return y;
   endfunction

   function automatic void push_level(int slot);
      if (stk_depth < DEPTH) begin
         stk_scope[stk_depth] = slot;
         stk_next[stk_depth]  = 0;
         stk_depth++;
      end
   endfunction

   function automatic bit find_link(int e, logic [15:0] tok, output int tgt);
      tgt = 0;
      for (int i = 0; i < ent_links[e]; i++) begin
         if (lnk_token[e*LINKS+i] == tok) begin
            tgt = lnk_target[e*LINKS+i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // next entry wins, else the first entry with that name
   function automatic bit find_named(int lvl, int s, logic [15:0] tok, output int e);
      int nx;
      nx = stk_next[lvl];
      e  = 0;
      if (nx < scope_count[s] && ent_name[s*ENTRIES+nx] == tok) begin
         e = s*ENTRIES + nx;
         stk_next[lvl] = nx + 1;
         return 1'b1;
      end
      for (int i = 0; i < scope_count[s]; i++) begin
         if (ent_name[s*ENTRIES+i] == tok) begin
            e = s*ENTRIES + i;
            stk_next[lvl] = i + 1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [2:0] push_target(int tgt);
      if (scope_live[tgt]) begin
         push_level(tgt);
         return STAT_OK;
      end
      push_level(NULL_SLOT);
      return STAT_NOT_FOUND;
   endfunction

   function automatic rsp_type predict_parse_event(req_type r);
      int          lvl, s, e, tgt, nx, saved, li;
      bit          done;
      logic [2:0]  st;
      logic [15:0] mx, mt;
      st   = STAT_OK;
      mx   = '0;
      mt   = '0;
      lvl  = 0;
      s    = NULL_SLOT;
      done = 1'b0;
      e    = int'(r.scope_slot)*ENTRIES + int'(r.entry_slot);
      if (r.command >= CMD_ENTER_NEXT && r.command <= CMD_LEAVE && stk_depth > 0) begin
         lvl = stk_depth - 1;
         s   = stk_scope[lvl];
         if (s >= SLOTS || !scope_live[s]) s = NULL_SLOT;
      end
      case (r.command)
         CMD_LOAD_SCOPE: begin
            slot_ident[r.scope_slot]  = r.scope_ident;
            scope_live[r.scope_slot]  = 1'b1;
            scope_count[r.scope_slot] = (r.item_count > ENTRIES) ? ENTRIES : r.item_count;
         end
         CMD_LOAD_ENTRY: begin
            ent_name[e]    = r.entry_token;
            ent_has[e]     = r.expr_present;
            ent_expr[e]    = r.expr_number;
            ent_links[e]   = (r.item_count > LINKS) ? LINKS : r.item_count;
            ent_written[e] = 1'b1;
         end
         CMD_LOAD_LINK: begin
            li              = e*LINKS + int'(r.link_slot);
            lnk_token[li]   = r.subscope_token;
            lnk_target[li]  = r.target_slot;
            lnk_written[li] = 1'b1;
         end
         CMD_SET_CURRENT: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (scope_live[i] && slot_ident[i] == r.scope_ident) s = i;
            stk_depth = 0;
            push_level(s);
            st = (s == NULL_SLOT) ? STAT_NOT_FOUND : STAT_OK;
         end
         CMD_ENTER_NEXT, CMD_ENTER_NAMED: begin
            if (stk_depth == 0) st = STAT_NO_SCOPE;
            else if (stk_depth >= DEPTH) st = STAT_OVERFLOW;
            else if (s == NULL_SLOT) begin
               push_level(NULL_SLOT);
               st = STAT_PARENT;
            end else begin
               if (r.command == CMD_ENTER_NEXT) begin
                  nx = stk_next[lvl];
                  st = STAT_MISMATCH;
                  if (nx < scope_count[s]) begin
                     e = s*ENTRIES + nx;
                     if (find_link(e, r.subscope_token, tgt)) begin
                        mt = ent_name[e];
                        stk_next[lvl] = nx + 1;
                        st   = push_target(tgt);
                        done = 1'b1;
                     end else st = STAT_KIND;
                  end
               end else begin
                  st = STAT_NOT_FOUND;
                  if (find_named(lvl, s, r.entry_token, e)) begin
                     mt = ent_name[e];
                     if (find_link(e, r.subscope_token, tgt)) begin
                        st   = push_target(tgt);
                        done = 1'b1;
                     end else st = STAT_KIND;
                  end
               end
               if (!done) push_level(NULL_SLOT);
            end
         end
         CMD_ENTRY_NEXT: begin
            if (stk_depth == 0) st = STAT_NO_SCOPE;
            else if (s == NULL_SLOT) st = STAT_PARENT;
            else begin
               st = STAT_MISMATCH;
               if (stk_next[lvl] < scope_count[s]) begin
                  e = s*ENTRIES + stk_next[lvl];
                  if (ent_has[e]) begin
                     mx = ent_expr[e];
                     mt = ent_name[e];
                     stk_next[lvl]++;
                     st = STAT_OK;
                  end
               end
            end
         end
         CMD_ENTRY_NAMED: begin
            if (stk_depth == 0) st = STAT_NO_SCOPE;
            else if (s == NULL_SLOT) st = STAT_PARENT;
            else begin
               saved = stk_next[lvl];
               st    = STAT_NOT_FOUND;
               if (find_named(lvl, s, r.entry_token, e)) begin
                  mt = ent_name[e];
                  if (ent_has[e]) begin
                     mx = ent_expr[e];
                     st = STAT_OK;
                  end else begin
                     stk_next[lvl] = saved;
                     st = STAT_KIND;
                  end
               end
            end
         end
         CMD_LEAVE: begin
            if (stk_depth == 0) st = STAT_NO_SCOPE;
            else stk_depth--;
         end
         CMD_CLEAR: begin
            stk_depth = 0;
            for (int i = 0; i < SLOTS; i++) scope_live[i] = 1'b0;
         end
         default: ;
      endcase
      return res(st, mx, mt, stk_depth);
   endfunction

   // keep loaded counts inside what has been written so no unwritten cell is read
   function automatic req_type keep_reads_defined(req_type r);
      int p, base;
      p = 0;
      if (r.command == CMD_LOAD_SCOPE) begin
         base = int'(r.scope_slot)*ENTRIES;
         while (p < ENTRIES && ent_written[base+p]) p++;
         if (r.item_count > p && p < ENTRIES) r.item_count = p[4:0];
      end else if (r.command == CMD_LOAD_ENTRY) begin
         base = (int'(r.scope_slot)*ENTRIES + int'(r.entry_slot))*LINKS;
         while (p < LINKS && lnk_written[base+p]) p++;
         if (r.item_count > p && p < LINKS) r.item_count = p[4:0];
      end
      return r;
   endfunction

   task automatic send_command(req_type r, bit typed, rsp_type typed_result);
      rsp_type y;
      int      gap;
      r = keep_reads_defined(r);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      y = predict_parse_event(r);
      pending_results.push_back(typed ? typed_result : y);
      status_seen[y.status]++;
      items_sent++;
      @(negedge clock);
      case ($urandom_range(0, 9))
         0, 1, 2:  gap = $urandom_range(1, 3);
         3:        gap = $urandom_range(10, 60);
         default:  gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send(req_type r);
      send_command(r, 1'b0, '0);
   endtask

   function automatic logic [15:0] pick_token();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h1234;
         3:       return 16'h00A5;
         4:       return 16'h5A5A;
         5:       return 16'h8001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_ident();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0101;
         3:       return 16'h7E7E;
         4:       return 16'h00C3;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic build_scope();
      int slot, n_ent, n_lnk;
      slot  = $urandom_range(0, SLOTS - 1);
      n_ent = ($urandom_range(0, 4) == 0) ? ENTRIES : $urandom_range(1, 4);
      for (int e = 0; e < n_ent; e++) begin
         n_lnk = ($urandom_range(0, 6) == 0) ? LINKS : $urandom_range(0, 3);
         for (int l = 0; l < n_lnk; l++)
            send(mk(CMD_LOAD_LINK, slot, 16'($urandom), e, l, 16'($urandom), pick_token(),
                    1'($urandom), 16'($urandom), $urandom_range(0, 31),
                    $urandom_range(0, SLOTS - 1)));
         send(mk(CMD_LOAD_ENTRY, slot, 16'($urandom), e, $urandom_range(0, 7), pick_token(),
                 16'($urandom), ($urandom_range(0, 3) != 0), 16'($urandom),
                 (n_lnk == LINKS) ? $urandom_range(LINKS, 31) : n_lnk,
                 $urandom_range(0, 15)));
      end
      send(mk(CMD_LOAD_SCOPE, slot, pick_ident(), $urandom_range(0, 15), $urandom_range(0, 7),
              16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
              (n_ent == ENTRIES) ? $urandom_range(ENTRIES, 31) : n_ent, $urandom_range(0, 15)));
   endtask

   function automatic req_type random_command(logic [3:0] cmd);
      req_type r;
      r = mk(cmd, $urandom_range(0, 15), pick_ident(), $urandom_range(0, 15),
             $urandom_range(0, 7), pick_token(), pick_token(), 1'($urandom), 16'($urandom),
             $urandom_range(0, 31), $urandom_range(0, 15));
      return r;
   endfunction

   task automatic walk_grammar();
      int n;
      send(random_command(CMD_SET_CURRENT));
      if ($urandom_range(0, 6) == 0) begin
         repeat (DEPTH + 3)
            send(random_command($urandom_range(0, 1) ? CMD_ENTER_NEXT : CMD_ENTER_NAMED));
      end
      n = $urandom_range(4, 30);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1:    send(random_command(CMD_ENTER_NEXT));
            2, 3:    send(random_command(CMD_ENTER_NAMED));
            4, 5:    send(random_command(CMD_ENTRY_NEXT));
            6, 7:    send(random_command(CMD_ENTRY_NAMED));
            8:       send(random_command(CMD_LEAVE));
            default: send(random_command(4'($urandom_range(0, 15))));
         endcase
      end
   endtask

   task automatic fill_directed();
      stim_row_type row;
      req_type      r[25];
      bit           t[25];
      rsp_type      y[25];
      for (int i = 0; i < 25; i++) begin
         t[i] = 1'b0;
         y[i] = '0;
      end
      r[0]  = mk(CMD_LEAVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[0] = 1; y[0] = res(STAT_NO_SCOPE, 0, 0, 0);
      r[1]  = mk(CMD_ENTER_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[1] = 1; y[1] = res(STAT_NO_SCOPE, 0, 0, 0);
      r[2]  = mk(CMD_ENTRY_NAMED, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0);
      t[2] = 1; y[2] = res(STAT_NO_SCOPE, 0, 0, 0);
      r[3]  = mk(CMD_SET_CURRENT, 0, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0);
      t[3] = 1; y[3] = res(STAT_NOT_FOUND, 0, 0, 1);
      r[4]  = mk(CMD_ENTRY_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[4] = 1; y[4] = res(STAT_PARENT, 0, 0, 1);
      r[5]  = mk(CMD_ENTER_NAMED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[5] = 1; y[5] = res(STAT_PARENT, 0, 0, 2);
      r[6]  = mk(4'd15, 15, 16'hFFFF, 15, 7, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 31, 15);
      t[6] = 1; y[6] = res(STAT_OK, 0, 0, 2);
      r[7]  = mk(4'd10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[7] = 1; y[7] = res(STAT_OK, 0, 0, 2);
      r[8]  = mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      t[8] = 1; y[8] = res(STAT_OK, 0, 0, 0);
      r[9]  = mk(CMD_LOAD_LINK, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 1);
      t[9] = 1; y[9] = res(STAT_OK, 0, 0, 0);
      r[10] = mk(CMD_LOAD_LINK, 15, 0, 15, 7, 0, 16'h0000, 0, 0, 0, 0);
      t[10] = 1; y[10] = res(STAT_OK, 0, 0, 0);
      r[11] = mk(CMD_LOAD_ENTRY, 0, 0, 0, 0, 16'hFFFF, 0, 1, 16'hFFFF, 1, 0);
      t[11] = 1; y[11] = res(STAT_OK, 0, 0, 0);
      r[12] = mk(CMD_LOAD_ENTRY, 0, 0, 1, 0, 16'h0000, 0, 0, 16'h0000, 0, 0);
      t[12] = 1; y[12] = res(STAT_OK, 0, 0, 0);
      r[13] = mk(CMD_LOAD_SCOPE, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
      r[14] = mk(CMD_LOAD_SCOPE, 0, 16'h0000, 0, 0, 0, 0, 0, 0, 2, 0);
      r[15] = mk(CMD_SET_CURRENT, 0, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0);
      t[15] = 1; y[15] = res(STAT_OK, 0, 0, 1);
      r[16] = mk(CMD_ENTRY_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      r[17] = mk(CMD_ENTRY_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      r[18] = mk(CMD_ENTRY_NAMED, 0, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0);
      r[19] = mk(CMD_ENTER_NAMED, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
      r[20] = mk(CMD_ENTRY_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      r[21] = mk(CMD_LEAVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      r[22] = mk(CMD_ENTER_NEXT, 0, 0, 0, 0, 0, 16'h0000, 0, 0, 0, 0);
      r[23] = mk(CMD_ENTER_NAMED, 0, 0, 0, 0, 16'h1234, 0, 0, 0, 0, 0);
      r[24] = mk(CMD_SET_CURRENT, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 25; i++) begin
         row.cmd    = r[i];
         row.typed  = t[i];
         row.result = y[i];
         directed_rows.push_back(row);
      end
   endtask

   // results are checked in order against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            if (want.status !== rsp_data.status || want.matched_expr !== rsp_data.matched_expr
                || want.matched_token !== rsp_data.matched_token
                || want.stack_level !== rsp_data.stack_level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch on result %0d: expected %p got %p",
                           results_seen, want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver with random back-pressure and one long hold-off
   initial begin
      int  n;
      bit  held;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else if ($urandom_range(0, 9) < 6) begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   initial begin
      int n_directed;
      mismatches   = 0;
      items_sent   = 0;
      results_seen = 0;
      idle_cycles  = 0;
      stk_depth    = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      for (int i = 0; i < SLOTS; i++) scope_live[i] = 1'b0;
      for (int i = 0; i < SLOTS*ENTRIES; i++) ent_written[i] = 1'b0;
      for (int i = 0; i < SLOTS*ENTRIES*LINKS; i++) lnk_written[i] = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      fill_directed();
      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].result);
      n_directed = items_sent;

      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: build_scope();
            5, 6, 7:       send(random_command(4'($urandom_range(0, 15))));
            default:       walk_grammar();
         endcase
      end
      req_valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (60) @(posedge clock);

      $display("sent %0d commands (%0d directed), checked %0d results", items_sent,
               n_directed, results_seen);
      $display("status counts ok %0d notfound %0d parent %0d kind %0d mismatch %0d none %0d ovf %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
src/sgt_pkg.sv
src/sgt_ram.sv
src/scope_grammar_tracker_unit.sv
test/scope_grammar_tracker_unit_test.sv
